FILE: rtl/ycc_mtx_pkg.sv
package ycc_mtx_pkg;

    // Field and datapath widths
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 18;
    localparam int NUM_COEF  = 3;
    localparam int ROW_W     = COEF_W * NUM_COEF;
    localparam int OP_W      = 18;
    localparam int PROD_W    = COEF_W + OP_W;
    localparam int ACC_W     = 40;
    localparam int NUM_LANES = 4;
    localparam int CFG_IDX_W = 2;

    // Output lanes, in result field order
    localparam int LANE_CB = 0;
    localparam int LANE_LA = 1;
    localparam int LANE_CR = 2;
    localparam int LANE_LB = 3;

    // Coefficient slots within a row
    localparam int COEF_Y = 0;
    localparam int COEF_U = 1;
    localparam int COEF_V = 2;

    // Sample offsets and limits
    localparam logic [SAMPLE_W-1:0] CHROMA_OFS_8  = 16'd128;
    localparam logic [SAMPLE_W-1:0] LUMA_OFS_8    = 16'd16;
    localparam logic [SAMPLE_W-1:0] CHROMA_OFS_16 = 16'd32768;
    localparam logic [SAMPLE_W-1:0] LUMA_OFS_16   = 16'd4096;
    localparam logic [SAMPLE_W-1:0] MAX_8         = 16'd255;
    localparam logic [SAMPLE_W-1:0] MAX_16        = 16'hFFFF;
    localparam logic [SAMPLE_W-1:0] ALPHA_OPAQUE  = 16'hFFFF;

    // Register reset values (unit diagonal)
    localparam logic [ROW_W-1:0] LUMA_ROW_RST = 54'd16384;
    localparam logic [ROW_W-1:0] CB_ROW_RST   = 54'd4294967296;
    localparam logic [ROW_W-1:0] CR_ROW_RST   = 54'd1125899906842624;

    typedef enum logic
    {
        MODE_UYVY = 1'b0,
        MODE_Y416 = 1'b1
    } pixel_mode_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_PIXEL_MODE = 2'd0,
        REG_LUMA_ROW   = 2'd1,
        REG_CB_ROW     = 2'd2,
        REG_CR_ROW     = 2'd3
    } cfg_reg_t;

    typedef struct packed
    {
        pixel_mode_t      mode;
        logic [ROW_W-1:0] luma_row;
        logic [ROW_W-1:0] cb_row;
        logic [ROW_W-1:0] cr_row;
    } cfg_t;

    typedef struct packed
    {
        logic [SAMPLE_W-1:0] cb;
        logic [SAMPLE_W-1:0] luma_a;
        logic [SAMPLE_W-1:0] cr;
        logic [SAMPLE_W-1:0] luma_b;
    } sample_t;

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef prod_t prod_arr_t [NUM_LANES][NUM_COEF];

endpackage

FILE: rtl/ycc_mtx_if.sv
// Input pixel channel
interface ycc_mtx_in_if;
    logic                           valid;
    logic                           ready;
    logic [ycc_mtx_pkg::SAMPLE_W-1:0] in_cb;
    logic [ycc_mtx_pkg::SAMPLE_W-1:0] in_luma_a;
    logic [ycc_mtx_pkg::SAMPLE_W-1:0] in_cr;
    logic [ycc_mtx_pkg::SAMPLE_W-1:0] in_luma_b;

    modport source (output valid, in_cb, in_luma_a, in_cr, in_luma_b, input ready);
    modport sink   (input valid, in_cb, in_luma_a, in_cr, in_luma_b, output ready);
endinterface

// Result pixel channel
interface ycc_mtx_out_if;
    logic                           valid;
    logic                           ready;
    logic [ycc_mtx_pkg::SAMPLE_W-1:0] out_cb;
    logic [ycc_mtx_pkg::SAMPLE_W-1:0] out_luma_a;
    logic [ycc_mtx_pkg::SAMPLE_W-1:0] out_cr;
    logic [ycc_mtx_pkg::SAMPLE_W-1:0] out_luma_b;

    modport source (output valid, out_cb, out_luma_a, out_cr, out_luma_b, input ready);
    modport sink   (input valid, out_cb, out_luma_a, out_cr, out_luma_b, output ready);
endinterface

// Register write channel
interface ycc_mtx_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [ycc_mtx_pkg::CFG_IDX_W-1:0] index;
    logic [ycc_mtx_pkg::ROW_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/ycc_mtx_cfg_regs.sv
module ycc_mtx_cfg_regs
(
    input  logic                clk,
    input  logic                rst_n,
    ycc_mtx_cfg_if.sink         cfg,
    output ycc_mtx_pkg::cfg_t   cfg_q
);

    ycc_mtx_pkg::cfg_t cfg_reg;

    // Writes are always taken
    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode     <= ycc_mtx_pkg::MODE_UYVY;
            cfg_reg.luma_row <= ycc_mtx_pkg::LUMA_ROW_RST;
            cfg_reg.cb_row   <= ycc_mtx_pkg::CB_ROW_RST;
            cfg_reg.cr_row   <= ycc_mtx_pkg::CR_ROW_RST;
        end
        else if (cfg.valid)
        begin
            unique case (ycc_mtx_pkg::cfg_reg_t'(cfg.index))
                ycc_mtx_pkg::REG_PIXEL_MODE:
                    cfg_reg.mode <= ycc_mtx_pkg::pixel_mode_t'(cfg.data[0]);
                ycc_mtx_pkg::REG_LUMA_ROW: cfg_reg.luma_row <= cfg.data;
                ycc_mtx_pkg::REG_CB_ROW:   cfg_reg.cb_row   <= cfg.data;
                ycc_mtx_pkg::REG_CR_ROW:   cfg_reg.cr_row   <= cfg.data;
                default: ;
            endcase
        end
    end

endmodule

FILE: rtl/ycc_mtx_mult.sv
module ycc_mtx_mult
(
    input  logic                      clk,
    input  logic                      en,
    input  ycc_mtx_pkg::sample_t      smp,
    input  ycc_mtx_pkg::cfg_t         cfg,
    output ycc_mtx_pkg::prod_arr_t    prod_reg
);

    localparam int OP_W   = ycc_mtx_pkg::OP_W;
    localparam int COEF_W = ycc_mtx_pkg::COEF_W;

    logic                     mode8;
    logic signed [OP_W-1:0]   u_c;
    logic signed [OP_W-1:0]   v_c;
    logic signed [OP_W-1:0]   y_a;
    logic signed [OP_W-1:0]   y_b;
    logic signed [OP_W-1:0]   y_sum;
    logic [ycc_mtx_pkg::ROW_W-1:0] row;
    logic signed [OP_W-1:0]   op [ycc_mtx_pkg::NUM_COEF];
    logic signed [COEF_W-1:0] coef;
    ycc_mtx_pkg::prod_arr_t   prod_next;

    // Centered samples, operand selection and products per lane
    always_comb
    begin
        mode8 = (cfg.mode == ycc_mtx_pkg::MODE_UYVY);
        if (mode8)
        begin
            u_c = OP_W'(smp.cb[7:0])     - OP_W'(ycc_mtx_pkg::CHROMA_OFS_8);
            v_c = OP_W'(smp.cr[7:0])     - OP_W'(ycc_mtx_pkg::CHROMA_OFS_8);
            y_a = OP_W'(smp.luma_a[7:0]) - OP_W'(ycc_mtx_pkg::LUMA_OFS_8);
            y_b = OP_W'(smp.luma_b[7:0]) - OP_W'(ycc_mtx_pkg::LUMA_OFS_8);
        end
        else
        begin
            u_c = OP_W'(smp.cb)     - OP_W'(ycc_mtx_pkg::CHROMA_OFS_16);
            v_c = OP_W'(smp.cr)     - OP_W'(ycc_mtx_pkg::CHROMA_OFS_16);
            y_a = OP_W'(smp.luma_a) - OP_W'(ycc_mtx_pkg::LUMA_OFS_16);
            y_b = y_a;
        end
        // Twice the average luma
        y_sum = y_a + y_b;

        for (int l = 0; l < ycc_mtx_pkg::NUM_LANES; l++)
        begin
            if (l == ycc_mtx_pkg::LANE_CB || l == ycc_mtx_pkg::LANE_CR)
            begin
                row = (l == ycc_mtx_pkg::LANE_CB) ? cfg.cb_row : cfg.cr_row;
                // 8-bit chroma rows carry one extra fraction bit
                if (mode8)
                begin
                    op[ycc_mtx_pkg::COEF_Y] = y_sum;
                    op[ycc_mtx_pkg::COEF_U] = u_c <<< 1;
                    op[ycc_mtx_pkg::COEF_V] = v_c <<< 1;
                end
                else
                begin
                    op[ycc_mtx_pkg::COEF_Y] = y_a;
                    op[ycc_mtx_pkg::COEF_U] = u_c;
                    op[ycc_mtx_pkg::COEF_V] = v_c;
                end
            end
            else
            begin
                row = cfg.luma_row;
                op[ycc_mtx_pkg::COEF_Y] = (l == ycc_mtx_pkg::LANE_LA) ? y_a : y_b;
                op[ycc_mtx_pkg::COEF_U] = u_c;
                op[ycc_mtx_pkg::COEF_V] = v_c;
            end
            for (int k = 0; k < ycc_mtx_pkg::NUM_COEF; k++)
            begin
                coef = $signed(row[k*COEF_W +: COEF_W]);
                prod_next[l][k] = coef * op[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

FILE: rtl/ycc_mtx_sat.sv
module ycc_mtx_sat
#(
    parameter int COEF_FRAC_BITS = 14
)
(
    input  logic                      clk,
    input  logic                      en,
    input  ycc_mtx_pkg::prod_arr_t    prod,
    input  ycc_mtx_pkg::cfg_t         cfg,
    output ycc_mtx_pkg::sample_t      res_reg
);

    localparam int ACC_W    = ycc_mtx_pkg::ACC_W;
    localparam int SAMPLE_W = ycc_mtx_pkg::SAMPLE_W;

    logic                       mode8;
    logic                       wide;
    logic [SAMPLE_W-1:0]        ofs;
    logic signed [ACC_W-1:0]    ofs_term;
    logic signed [ACC_W-1:0]    acc;
    logic [ACC_W-1:0]           shr;
    logic [ACC_W-1:0]           maxv;
    logic [SAMPLE_W-1:0]        lane_res [ycc_mtx_pkg::NUM_LANES];
    ycc_mtx_pkg::sample_t       res_next;

    // Sum, add offset back, floor and clamp per lane
    always_comb
    begin
        mode8 = (cfg.mode == ycc_mtx_pkg::MODE_UYVY);
        maxv  = mode8 ? ACC_W'(ycc_mtx_pkg::MAX_8) : ACC_W'(ycc_mtx_pkg::MAX_16);
        for (int l = 0; l < ycc_mtx_pkg::NUM_LANES; l++)
        begin
            if (l == ycc_mtx_pkg::LANE_CB || l == ycc_mtx_pkg::LANE_CR)
            begin
                ofs = mode8 ? ycc_mtx_pkg::CHROMA_OFS_8 : ycc_mtx_pkg::CHROMA_OFS_16;
                wide = mode8;
            end
            else
            begin
                ofs = mode8 ? ycc_mtx_pkg::LUMA_OFS_8 : ycc_mtx_pkg::LUMA_OFS_16;
                wide = 1'b0;
            end
            ofs_term = wide ? $signed(ACC_W'(ofs) << (COEF_FRAC_BITS + 1))
                            : $signed(ACC_W'(ofs) << COEF_FRAC_BITS);
            acc = ACC_W'(prod[l][ycc_mtx_pkg::COEF_Y])
                + ACC_W'(prod[l][ycc_mtx_pkg::COEF_U])
                + ACC_W'(prod[l][ycc_mtx_pkg::COEF_V])
                + ofs_term;
            shr = wide ? (ACC_W'(acc) >> (COEF_FRAC_BITS + 1))
                       : (ACC_W'(acc) >> COEF_FRAC_BITS);
            if (acc[ACC_W-1])
            begin
                lane_res[l] = '0;
            end
            else if (shr > maxv)
            begin
                lane_res[l] = maxv[SAMPLE_W-1:0];
            end
            else
            begin
                lane_res[l] = shr[SAMPLE_W-1:0];
            end
        end
        res_next.cb     = lane_res[ycc_mtx_pkg::LANE_CB];
        res_next.luma_a = lane_res[ycc_mtx_pkg::LANE_LA];
        res_next.cr     = lane_res[ycc_mtx_pkg::LANE_CR];
        // Y416 alpha is forced opaque
        res_next.luma_b = mode8 ? lane_res[ycc_mtx_pkg::LANE_LB]
                                : ycc_mtx_pkg::ALPHA_OPAQUE;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

endmodule

FILE: rtl/ycbcr_matrix_transform_core.sv
// YCbCr 3x3 color matrix.
// pixel:  input channel; one UYVY macropixel (pixel_mode 0, low 8 bits of each
//         field) or one Y416 pixel (pixel_mode 1, in_luma_b ignored) per transfer.
// result: output channel; transformed Cb, luma A, Cr, luma B (65535 in Y416).
// cfg:    register write channel, always ready; index 0 pixel_mode, 1..3 the
//         luma, Cb and Cr coefficient rows (three signed 18-bit values each,
//         COEF_FRAC_BITS fraction bits, packed low to high). Write only while
//         no pixel is in flight.
// Pipeline: input register, product register (one multiplier per term),
// result register after sum, floor and saturate. A pixel passes these three
// registers in order before its result is valid; throughput is one pixel per
// clock while result.ready holds.
// Each stage advances when the one after it is empty or moving, so the block
// keeps taking pixels while a result waits until all three stages are full;
// only then does pixel.ready drop.
// Reset empties the pipeline and loads the unit matrix in UYVY mode.
module ycbcr_matrix_transform_core
#(
    parameter int COEF_FRAC_BITS = 14
)
(
    input  logic            clk,
    input  logic            rst_n,
    ycc_mtx_in_if.sink      pixel,
    ycc_mtx_out_if.source   result,
    ycc_mtx_cfg_if.sink     cfg
);

    ycc_mtx_pkg::cfg_t      cfg_q;
    ycc_mtx_pkg::sample_t   smp_reg;
    ycc_mtx_pkg::prod_arr_t prod_reg;
    ycc_mtx_pkg::sample_t   res_reg;
    logic                   v1_reg;
    logic                   v2_reg;
    logic                   v3_reg;
    logic                   en1;
    logic                   en2;
    logic                   en3;

    // Stage enables
    assign en3         = !v3_reg || result.ready;
    assign en2         = !v2_reg || en3;
    assign en1         = !v1_reg || en2;
    assign pixel.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= pixel.valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            smp_reg.cb     <= pixel.in_cb;
            smp_reg.luma_a <= pixel.in_luma_a;
            smp_reg.cr     <= pixel.in_cr;
            smp_reg.luma_b <= pixel.in_luma_b;
        end
    end

    ycc_mtx_cfg_regs u_cfg_regs
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    ycc_mtx_mult u_mult
    (
        .clk      (clk),
        .en       (en2),
        .smp      (smp_reg),
        .cfg      (cfg_q),
        .prod_reg (prod_reg)
    );

    ycc_mtx_sat
    #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    )
    u_sat
    (
        .clk     (clk),
        .en      (en3),
        .prod    (prod_reg),
        .cfg     (cfg_q),
        .res_reg (res_reg)
    );

    assign result.valid      = v3_reg;
    assign result.out_cb     = res_reg.cb;
    assign result.out_luma_a = res_reg.luma_a;
    assign result.out_cr     = res_reg.cr;
    assign result.out_luma_b = res_reg.luma_b;

    // Backpressure only when every stage holds a pixel
    a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel.ready |-> (v1_reg && v2_reg && v3_reg))
        else $error("input stalled with an empty stage");

    // An input transfer always lands in the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel.valid && pixel.ready) |=> v1_reg)
        else $error("accepted pixel lost");

    // UYVY results stay within 8 bits
    a_uyvy_range: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && cfg_q.mode == ycc_mtx_pkg::MODE_UYVY) |->
        (result.out_cb[15:8] == 8'd0 && result.out_luma_a[15:8] == 8'd0 &&
         result.out_cr[15:8] == 8'd0 && result.out_luma_b[15:8] == 8'd0))
        else $error("8-bit result out of range");

    // Y416 alpha is opaque
    a_y416_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && cfg_q.mode == ycc_mtx_pkg::MODE_Y416) |->
        (result.out_luma_b == ycc_mtx_pkg::ALPHA_OPAQUE))
        else $error("Y416 alpha not opaque");

endmodule

FILE: sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS         = 14;
    localparam int ITEMS_PER_SETTING = 138;
    localparam int NUM_SETTINGS      = 12;
    localparam int COEF_MAX          = 131071;
    localparam int COEF_MIN          = -131072;
    localparam int COEF_ONE          = 1 << FRAC_BITS;
    localparam int ROW_W             = ycc_mtx_pkg::ROW_W;
    localparam int SAMPLE_W          = ycc_mtx_pkg::SAMPLE_W;
    localparam int COEF_W            = ycc_mtx_pkg::COEF_W;
    localparam int NUM_LANES         = ycc_mtx_pkg::NUM_LANES;

    // Expected-result tracker: mirrors the register file and the datapath
    class ycc_matrix_scoreboard;
        ycc_mtx_pkg::pixel_mode_t mode;
        logic [ROW_W-1:0]         luma_row;
        logic [ROW_W-1:0]         cb_row;
        logic [ROW_W-1:0]         cr_row;
        ycc_mtx_pkg::sample_t     expected_pixels[$];
        int                       errors;
        int                       checked;

        function new();
            mode     = ycc_mtx_pkg::MODE_UYVY;
            luma_row = ycc_mtx_pkg::LUMA_ROW_RST;
            cb_row   = ycc_mtx_pkg::CB_ROW_RST;
            cr_row   = ycc_mtx_pkg::CR_ROW_RST;
            errors   = 0;
            checked  = 0;
        endfunction

        function void set_reg(ycc_mtx_pkg::cfg_reg_t idx, logic [ROW_W-1:0] value);
            case (idx)
                ycc_mtx_pkg::REG_PIXEL_MODE: mode = ycc_mtx_pkg::pixel_mode_t'(value[0]);
                ycc_mtx_pkg::REG_LUMA_ROW:   luma_row = value;
                ycc_mtx_pkg::REG_CB_ROW:     cb_row = value;
                ycc_mtx_pkg::REG_CR_ROW:     cr_row = value;
                default: ;
            endcase
        endfunction

        function longint coef(logic [ROW_W-1:0] row, int k);
            logic signed [COEF_W-1:0] raw;
            raw = row[k*COEF_W +: COEF_W];
            return longint'(raw);
        endfunction

        // Offset plus weighted sum; luma carries 2^extra scale, then floor and clamp
        function logic [SAMPLE_W-1:0] apply_row(logic [ROW_W-1:0] row, longint ofs,
                                                longint yv, longint u, longint v,
                                                int extra, longint top);
            longint acc;
            int     shift;
            shift = FRAC_BITS + extra;
            acc = (ofs <<< shift) + coef(row, ycc_mtx_pkg::COEF_Y) * yv
                + ((coef(row, ycc_mtx_pkg::COEF_U) * u
                    + coef(row, ycc_mtx_pkg::COEF_V) * v) <<< extra);
            if (acc < 0)
                return '0;
            acc = acc >>> shift;
            if (acc > top)
                acc = top;
            return acc[SAMPLE_W-1:0];
        endfunction

        function ycc_mtx_pkg::sample_t transform_pixel(ycc_mtx_pkg::sample_t px);
            ycc_mtx_pkg::sample_t r;
            longint               u, y1, v, y2, co, yo, top;
            if (mode == ycc_mtx_pkg::MODE_UYVY)
            begin
                co  = ycc_mtx_pkg::CHROMA_OFS_8;
                yo  = ycc_mtx_pkg::LUMA_OFS_8;
                top = ycc_mtx_pkg::MAX_8;
                u   = px.cb[7:0];
                y1  = px.luma_a[7:0];
                v   = px.cr[7:0];
                y2  = px.luma_b[7:0];
                u   = u - co;
                y1  = y1 - yo;
                v   = v - co;
                y2  = y2 - yo;
                // chroma rows use the luma sum, i.e. twice the average
                r.cb     = apply_row(cb_row, co, y1 + y2, u, v, 1, top);
                r.luma_a = apply_row(luma_row, yo, y1, u, v, 0, top);
                r.cr     = apply_row(cr_row, co, y1 + y2, u, v, 1, top);
                r.luma_b = apply_row(luma_row, yo, y2, u, v, 0, top);
            end
            else
            begin
                co  = ycc_mtx_pkg::CHROMA_OFS_16;
                yo  = ycc_mtx_pkg::LUMA_OFS_16;
                top = ycc_mtx_pkg::MAX_16;
                u   = px.cb;
                y1  = px.luma_a;
                v   = px.cr;
                u   = u - co;
                y1  = y1 - yo;
                v   = v - co;
                r.cb     = apply_row(cb_row, co, y1, u, v, 0, top);
                r.luma_a = apply_row(luma_row, yo, y1, u, v, 0, top);
                r.cr     = apply_row(cr_row, co, y1, u, v, 0, top);
                r.luma_b = ycc_mtx_pkg::ALPHA_OPAQUE;
            end
            return r;
        endfunction

        function void note_pixel(ycc_mtx_pkg::sample_t px);
            expected_pixels.push_back(transform_pixel(px));
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(ycc_mtx_pkg::sample_t got);
            ycc_mtx_pkg::sample_t want;
            string   lane_name[NUM_LANES] = '{"out_cb", "out_luma_a", "out_cr", "out_luma_b"};
            if (expected_pixels.size() == 0)
            begin
                report($sformatf("result %h with nothing outstanding", got));
                return;
            end
            want = expected_pixels.pop_front();
            checked++;
            for (int l = 0; l < NUM_LANES; l++)
            begin
                if (got[(NUM_LANES-1-l)*SAMPLE_W +: SAMPLE_W]
                    !== want[(NUM_LANES-1-l)*SAMPLE_W +: SAMPLE_W])
                    report($sformatf("result %0d %s got %h expected %h", checked,
                                     lane_name[l],
                                     got[(NUM_LANES-1-l)*SAMPLE_W +: SAMPLE_W],
                                     want[(NUM_LANES-1-l)*SAMPLE_W +: SAMPLE_W]));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   quiet = 1'b0;
    int   gap_odds = 0;
    int   n_settings = 0;

    ycc_matrix_scoreboard sb = new();

    ycc_mtx_in_if  pixel_ch();
    ycc_mtx_out_if result_ch();
    ycc_mtx_cfg_if cfg_ch();

    ycbcr_matrix_transform_core #(.COEF_FRAC_BITS(FRAC_BITS)) uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pixel_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always #10 clk = ~clk;

    // Transfer monitor: results checked, accepted pixels predicted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
                sb.check_result({result_ch.out_cb, result_ch.out_luma_a,
                                 result_ch.out_cr, result_ch.out_luma_b});
            if (pixel_ch.valid && pixel_ch.ready)
                sb.note_pixel({pixel_ch.in_cb, pixel_ch.in_luma_a,
                               pixel_ch.in_cr, pixel_ch.in_luma_b});
        end
    end

    // Result sink with random stall bursts and calm stretches
    initial
    begin
        int stall_left;
        int calm_left;
        stall_left = 0;
        calm_left  = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                if (calm_left > 0)
                    calm_left--;
                else if (!quiet)
                begin
                    case ($urandom_range(0, 19))
                        0, 1, 2: stall_left = $urandom_range(1, 14);
                        3:       calm_left = $urandom_range(20, 200);
                        default: ;
                    endcase
                end
            end
        end
    end

    function automatic logic [ROW_W-1:0] pack_row(int c0, int c1, int c2);
        logic [31:0] a, b, c;
        a = c0;
        b = c1;
        c = c2;
        return {c[COEF_W-1:0], b[COEF_W-1:0], a[COEF_W-1:0]};
    endfunction

    // Mostly random samples, some at the edges and around the offset
    function automatic logic [SAMPLE_W-1:0] rand_field(logic [SAMPLE_W-1:0] ofs);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return ofs + SAMPLE_W'($urandom_range(0, 4)) - SAMPLE_W'(2);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic send_pixel(input ycc_mtx_pkg::sample_t px);
        @(negedge clk);
        pixel_ch.valid     <= 1'b1;
        pixel_ch.in_cb     <= px.cb;
        pixel_ch.in_luma_a <= px.luma_a;
        pixel_ch.in_cr     <= px.cr;
        pixel_ch.in_luma_b <= px.luma_b;
        do
            @(posedge clk);
        while (!pixel_ch.ready);
    endtask

    // Valid-low gap, with junk on the bus
    task automatic pixel_gap(input int n);
        @(negedge clk);
        pixel_ch.valid     <= 1'b0;
        pixel_ch.in_cb     <= SAMPLE_W'($urandom);
        pixel_ch.in_luma_a <= SAMPLE_W'($urandom);
        pixel_ch.in_cr     <= SAMPLE_W'($urandom);
        pixel_ch.in_luma_b <= SAMPLE_W'($urandom);
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        pixel_ch.valid <= 1'b0;
        while (sb.expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input ycc_mtx_pkg::cfg_reg_t idx,
                             input logic [ROW_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        sb.set_reg(idx, value);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic write_matrix(input logic [ROW_W-1:0] luma, input logic [ROW_W-1:0] cb,
                                input logic [ROW_W-1:0] cr);
        write_reg(ycc_mtx_pkg::REG_LUMA_ROW, luma);
        write_reg(ycc_mtx_pkg::REG_CB_ROW, cb);
        write_reg(ycc_mtx_pkg::REG_CR_ROW, cr);
        n_settings++;
    endtask

    task automatic run_directed(input ycc_mtx_pkg::sample_t px_list[$]);
        foreach (px_list[i])
            send_pixel(px_list[i]);
        wait_drained();
    endtask

    // Stimulus
    initial
    begin
        logic [ROW_W-1:0]         rows[3];
        logic [ROW_W-1:0]         mode_word;
        logic [SAMPLE_W-1:0]      co, yo;
        ycc_mtx_pkg::pixel_mode_t m;
        int                       n_directed;

        rst_n = 1'b0;
        pixel_ch.valid     <= 1'b0;
        pixel_ch.in_cb     <= '0;
        pixel_ch.in_luma_a <= '0;
        pixel_ch.in_cr     <= '0;
        pixel_ch.in_luma_b <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= ycc_mtx_pkg::REG_PIXEL_MODE;
        cfg_ch.data        <= '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // UYVY, unit matrix after reset: pass-through, upper bits ignored
        run_directed('{64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
                       64'h0080_0010_0080_0010, 64'hFF80_AB10_0080_CD10,
                       64'h0000_00FF_00FF_0000});

        // UYVY, matrix with luma in the chroma rows: averaging, floor, saturation
        write_matrix(pack_row(COEF_ONE, COEF_ONE, COEF_ONE),
                     pack_row(COEF_ONE / 2, COEF_ONE, -COEF_ONE),
                     pack_row(-COEF_ONE, COEF_ONE / 4, 2 * COEF_ONE));
        run_directed('{64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
                       64'h0080_0010_0080_0010, 64'h0080_0011_0080_0010,
                       64'h0080_0010_0080_00FF, 64'h00FF_0000_0000_00FF});

        // Y416, same matrix: alpha forced, full 16-bit range
        write_reg(ycc_mtx_pkg::REG_PIXEL_MODE, ROW_W'(ycc_mtx_pkg::MODE_Y416));
        run_directed('{64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
                       64'h8000_1000_8000_1234, 64'h8000_1001_8000_0000,
                       64'hFFFF_0000_0000_FFFF});

        // Y416, unit matrix
        write_matrix(ycc_mtx_pkg::LUMA_ROW_RST, ycc_mtx_pkg::CB_ROW_RST,
                     ycc_mtx_pkg::CR_ROW_RST);
        run_directed('{64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
                       64'h0001_FFFE_8001_0000});
        n_directed = sb.checked;

        // Random pixels over a sweep of matrices in both modes
        for (int p = 0; p < NUM_SETTINGS; p++)
        begin
            m     = (p % 2 != 0) ? ycc_mtx_pkg::MODE_Y416 : ycc_mtx_pkg::MODE_UYVY;
            quiet = (p >= NUM_SETTINGS - 2);
            case (p / 2)
                0:
                    for (int r = 0; r < 3; r++)
                        rows[r] = pack_row(COEF_MAX, COEF_MAX, COEF_MAX);
                1:
                    for (int r = 0; r < 3; r++)
                        rows[r] = pack_row(COEF_MIN, COEF_MIN, COEF_MIN);
                2: for (int r = 0; r < 3; r++) rows[r] = '0;
                3:
                begin
                    rows[0] = ycc_mtx_pkg::LUMA_ROW_RST;
                    rows[1] = ycc_mtx_pkg::CB_ROW_RST;
                    rows[2] = ycc_mtx_pkg::CR_ROW_RST;
                end
                4: for (int r = 0; r < 3; r++) rows[r] = ROW_W'({$urandom, $urandom});
                default:
                    for (int r = 0; r < 3; r++)
                        rows[r] = pack_row(int'($urandom_range(0, 65536)) - 32768,
                                           int'($urandom_range(0, 65536)) - 32768,
                                           int'($urandom_range(0, 65536)) - 32768);
            endcase
            // only bit 0 of the mode register matters; the rest is noise
            mode_word    = ROW_W'({$urandom, $urandom});
            mode_word[0] = m;
            write_reg(ycc_mtx_pkg::REG_PIXEL_MODE, mode_word);
            write_matrix(rows[0], rows[1], rows[2]);

            co = (m == ycc_mtx_pkg::MODE_UYVY) ? ycc_mtx_pkg::CHROMA_OFS_8
                                               : ycc_mtx_pkg::CHROMA_OFS_16;
            yo = (m == ycc_mtx_pkg::MODE_UYVY) ? ycc_mtx_pkg::LUMA_OFS_8
                                               : ycc_mtx_pkg::LUMA_OFS_16;
            case ($urandom_range(0, 2))
                0:       gap_odds = 0;
                1:       gap_odds = 3;
                default: gap_odds = 8;
            endcase
            if (quiet)
                gap_odds = 0;

            repeat (ITEMS_PER_SETTING)
            begin
                if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
                    pixel_gap($urandom_range(1, 14));
                send_pixel({rand_field(co), rand_field(yo), rand_field(co), rand_field(yo)});
            end
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (sb.expected_pixels.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_pixels.size()));

        $display("Checked %0d results (%0d directed) across %0d coefficient settings,",
                 sb.checked, n_directed, n_settings);
        $display("both pixel modes, with random stalls on the input and result channels.");
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("Timeout with %0d results outstanding", sb.expected_pixels.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
